>>> hw/rtl/ssmms_pkg.sv
// Package with shared widths, types and codes for the sample set statistics unit.
`timescale 1ns / 1ps

package ssmms_pkg;

  localparam int unsigned MaxSamplesDef = 65536;
  localparam int unsigned CntW  = 17;
  localparam int unsigned SumW  = 34;
  localparam int unsigned SqW   = 47;
  localparam int unsigned ProdW = 64;
  localparam int unsigned NumW  = 80;
  localparam int unsigned RemW  = 34;
  localparam int unsigned StepW = 7;

  localparam logic [StepW-1:0] MsqSteps  = 7'd34;
  localparam logic [StepW-1:0] MnsSteps  = 7'd17;
  localparam logic [StepW-1:0] DivSteps  = 7'd80;
  localparam logic [StepW-1:0] SqrtSteps = 7'd24;

  typedef enum logic [2:0] {
    S_ACC, S_MSQ, S_MNS, S_DVAR, S_DMEAN, S_SQRT, S_OUT
  } ssmms_state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_MSQ, OP_MNS, OP_DVAR, OP_DMEAN, OP_SQRT
  } ssmms_op_t;

  typedef struct packed {
    logic      acc;
    ssmms_op_t op;
    logic      init;
    logic      step;
    logic      finish;
  } ssmms_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } ssmms_stat_t;

endpackage

>>> hw/rtl/ssmms_ctrl.sv
// Controller state machine that sequences accumulation and the final arithmetic phases.
`timescale 1ns / 1ps

module ssmms_ctrl
  import ssmms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  input  ssmms_stat_t stat,
  output logic        in_stall,
  output ssmms_cmd_t  cmd
);

  ssmms_state_t state_r, state_nxt;
  logic         first_r, first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    first_nxt  = first_r;
    cmd        = '0;
    cmd.op     = OP_NONE;
    in_stall   = 1'b1;
    unique case (state_r)
      S_ACC: begin
        in_stall = 1'b0;
        cmd.acc  = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_MSQ;
          first_nxt = 1'b1;
        end
      end
      S_MSQ, S_MNS, S_DVAR, S_DMEAN, S_SQRT: begin
        unique case (state_r)
          S_MSQ:   cmd.op = OP_MSQ;
          S_MNS:   cmd.op = OP_MNS;
          S_DVAR:  cmd.op = OP_DVAR;
          S_DMEAN: cmd.op = OP_DMEAN;
          default: cmd.op = OP_SQRT;
        endcase
        if (first_r) begin
          cmd.init  = 1'b1;
          first_nxt = 1'b0;
        end else begin
          cmd.step = 1'b1;
          if (stat.last) begin
            first_nxt = 1'b1;
            unique case (state_r)
              S_MSQ:   state_nxt = S_MNS;
              S_MNS:   state_nxt = S_DVAR;
              S_DVAR:  state_nxt = S_DMEAN;
              S_DMEAN: state_nxt = S_SQRT;
              default: begin
                state_nxt = S_OUT;
                first_nxt = 1'b0;
              end
            endcase
          end
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

endmodule

>>> hw/rtl/ssmms_dp.sv
// Datapath: accumulators, shift-add multiplier, restoring divider, square root, result register.
`timescale 1ns / 1ps

module ssmms_dp
  import ssmms_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssmms_cmd_t         cmd,
  input  logic signed [15:0] in_sample,
  input  logic               out_stall,
  output ssmms_stat_t        stat,
  output logic               out_valid,
  output logic signed [15:0] out_minimum,
  output logic signed [23:0] out_mean_q8,
  output logic        [22:0] out_std_dev_q8,
  output logic        [16:0] out_sample_total,
  output logic               out_overflowed
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);

  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic [SqW-1:0]         sq_r, sq_nxt;
  logic signed [15:0]     min_r, min_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [ProdW-1:0] acc_r, acc_nxt, ma_r, ma_nxt, t_r, t_nxt;
  logic [SumW-1:0]  mb_r, mb_nxt;
  logic [NumW-1:0]  num_r, num_nxt;
  logic [RemW-1:0]  rem_r, rem_nxt, div_r, div_nxt;
  logic [SqW-1:0]   var_r, var_nxt;
  logic [47:0]      sx_r, sx_nxt;
  logic [25:0]      sr_r, sr_nxt;
  logic [23:0]      root_r, root_nxt;
  logic [23:0]      mean_r, mean_nxt;
  logic [StepW-1:0] step_r, step_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic signed [15:0] omin_r;
  logic [23:0]        omean_r;
  logic [22:0]        osd_r;
  logic [16:0]        otot_r;
  logic               oovf_r;

  logic signed [31:0] prod;
  logic [SumW-1:0]    mag;
  logic [RemW-1:0]    trial;
  logic               ge;
  logic [25:0]        srem, stry;
  logic [40:0]        qmag;
  logic [StepW-1:0]   limit;

  assign prod = in_sample * in_sample;
  assign mag  = sum_r[SumW-1] ? SumW'(-sum_r) : SumW'(sum_r);
  assign trial = {rem_r[RemW-2:0], num_r[NumW-1]};
  assign ge    = trial >= div_r;
  assign srem  = {sr_r[23:0], sx_r[47:46]};
  assign stry  = {root_r, 2'b01};
  // The floored negative mean rounds the magnitude up when the division is not exact.
  assign qmag  = {1'b0, num_r[39:0]} + {40'b0, (rem_r != '0)};

  always_comb begin
    case (cmd.op)
      OP_MSQ:  limit = MsqSteps;
      OP_MNS:  limit = MnsSteps;
      OP_SQRT: limit = SqrtSteps;
      default: limit = DivSteps;
    endcase
  end

  assign stat.last     = (step_r == limit - 7'd1);
  assign stat.out_free = !ovalid_r || !out_stall;

  always_comb begin
    sum_nxt = sum_r; sq_nxt = sq_r; min_nxt = min_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r;
    acc_nxt = acc_r; ma_nxt = ma_r; mb_nxt = mb_r; t_nxt = t_r;
    num_nxt = num_r; rem_nxt = rem_r; div_nxt = div_r; var_nxt = var_r;
    sx_nxt = sx_r; sr_nxt = sr_r; root_nxt = root_r; mean_nxt = mean_r;
    step_nxt = step_r;
    ovalid_nxt = ovalid_r && out_stall;

    if (cmd.acc) begin
      if (cnt_r != MaxCnt) begin
        sum_nxt = sum_r + SumW'(in_sample);
        sq_nxt  = sq_r + {15'b0, prod};
        if (in_sample < min_r) min_nxt = in_sample;
        cnt_nxt = cnt_r + 17'd1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.init) begin
      step_nxt = '0;
      case (cmd.op)
        OP_MSQ: begin
          acc_nxt = '0;
          ma_nxt  = {30'b0, mag};
          mb_nxt  = mag;
        end
        OP_MNS: begin
          t_nxt   = acc_r;
          acc_nxt = '0;
          ma_nxt  = {17'b0, sq_r};
          mb_nxt  = {17'b0, cnt_r};
        end
        OP_DVAR: begin
          num_nxt = {acc_r - t_r, 16'b0};
          div_nxt = cnt_r * cnt_r;
          rem_nxt = '0;
        end
        OP_DMEAN: begin
          var_nxt = num_r[SqW-1:0];
          num_nxt = {38'b0, mag, 8'b0};
          div_nxt = {17'b0, cnt_r};
          rem_nxt = '0;
        end
        OP_SQRT: begin
          mean_nxt = sum_r[SumW-1] ? 24'(-qmag) : num_r[23:0];
          sx_nxt   = {1'b0, var_r};
          sr_nxt   = '0;
          root_nxt = '0;
        end
        default: ;
      endcase
    end

    if (cmd.step) begin
      step_nxt = step_r + 7'd1;
      case (cmd.op)
        OP_MSQ, OP_MNS: begin
          if (mb_r[0]) acc_nxt = acc_r + ma_r;
          ma_nxt = {ma_r[ProdW-2:0], 1'b0};
          mb_nxt = {1'b0, mb_r[SumW-1:1]};
        end
        OP_DVAR, OP_DMEAN: begin
          rem_nxt = ge ? trial - div_r : trial;
          num_nxt = {num_r[NumW-2:0], ge};
        end
        OP_SQRT: begin
          sx_nxt = {sx_r[45:0], 2'b00};
          if (srem >= stry) begin
            sr_nxt   = srem - stry;
            root_nxt = {root_r[22:0], 1'b1};
          end else begin
            sr_nxt   = srem;
            root_nxt = {root_r[22:0], 1'b0};
          end
        end
        default: ;
      endcase
    end

    if (cmd.finish) begin
      ovalid_nxt = 1'b1;
      sum_nxt = '0; sq_nxt = '0; min_nxt = 16'sh7fff; cnt_nxt = '0; ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      sq_r     <= '0;
      min_r    <= 16'sh7fff;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      step_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      sq_r     <= sq_nxt;
      min_r    <= min_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; ma_r <= ma_nxt; mb_r <= mb_nxt; t_r <= t_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; div_r <= div_nxt; var_r <= var_nxt;
    sx_r <= sx_nxt; sr_r <= sr_nxt; root_r <= root_nxt; mean_r <= mean_nxt;
    if (cmd.finish) begin
      omin_r  <= min_r;
      omean_r <= mean_r;
      osd_r   <= root_r[22:0];
      otot_r  <= cnt_r;
      oovf_r  <= ovf_r;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_minimum      = omin_r;
  assign out_mean_q8      = omean_r;
  assign out_std_dev_q8   = osd_r;
  assign out_sample_total = otot_r;
  assign out_overflowed   = oovf_r;

endmodule

>>> hw/rtl/sample_set_min_mean_stddev_unit.sv
// Sample set minimum, mean and population standard deviation unit, top level.
// Samples are accumulated at one beat per cycle while the unit is collecting a set.
// After the last beat the unit runs shift-add multiply, restoring divide and bit-pair square
// root steps, then registers the result in the output register.
// Input stalls from the last beat until the result is loaded into the output register.
// Synchronous active-low reset clears the accumulators, the controller and the output valid.
`timescale 1ns / 1ps

module sample_set_min_mean_stddev_unit
  import ssmms_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_minimum,
  output logic signed [23:0] out_mean_q8,
  output logic        [22:0] out_std_dev_q8,
  output logic        [16:0] out_sample_total,
  output logic               out_overflowed
);

  ssmms_cmd_t  cmd;
  ssmms_stat_t stat;

  ssmms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ssmms_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_sample        (in_sample),
    .out_stall        (out_stall),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_minimum      (out_minimum),
    .out_mean_q8      (out_mean_q8),
    .out_std_dev_q8   (out_std_dev_q8),
    .out_sample_total (out_sample_total),
    .out_overflowed   (out_overflowed)
  );

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_total != 17'd0) && (out_sample_total <= 17'(MAX_SAMPLES)))
    else $error("result sample count out of range");

  a_mean_above_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_mean_q8) >= $signed({out_minimum, 8'b0})))
    else $error("mean below minimum");

  a_result_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while collecting samples");

endmodule

>>> verif/tb_sample_set_min_mean_stddev_unit.sv
// Testbench for the sample set minimum, mean and standard deviation unit.
`timescale 1ns / 1ps

module tb_sample_set_min_mean_stddev_unit;
  import ssmms_pkg::*;

  localparam int unsigned Capacity = 65536;
  localparam int unsigned IdleLimit = 5000;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    logic               drain;
    logic               calm;
  } beat_t;

  typedef struct {
    logic signed [15:0] minimum;
    logic signed [23:0] mean_q8;
    logic        [22:0] std_dev_q8;
    logic        [16:0] sample_total;
    logic               overflowed;
  } set_stats_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_minimum;
  logic signed [23:0] out_mean_q8;
  logic        [22:0] out_std_dev_q8;
  logic        [16:0] out_sample_total;
  logic               out_overflowed;

  beat_t      pending_beats[$];
  set_stats_t expected_stats[$];
  logic       in_taken = 1'b0;
  logic       calm = 1'b0;
  logic       draining = 1'b0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         idle_cycles = 0;
  int         fail_count = 0;

  // Running statistics of the open set.
  longint            set_sum = 0;
  longint unsigned   set_sqsum = 0;
  int                set_min = 32767;
  int unsigned       set_count = 0;
  logic              set_ovf = 1'b0;

  sample_set_min_mean_stddev_unit i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample, .in_last,
    .out_valid, .out_stall, .out_minimum, .out_mean_q8, .out_std_dev_q8,
    .out_sample_total, .out_overflowed
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic set_stats_t stats_for_set();
    set_stats_t      st;
    longint          n;
    longint          scaled;
    longint          mean;
    longint unsigned mag;
    longint unsigned d;
    longint unsigned n2;
    longint unsigned var_q16;
    n = set_count;
    scaled = set_sum * 256;
    mean = scaled / n;
    if ((scaled % n) != 0 && scaled < 0) mean = mean - 1;
    mag = (set_sum < 0) ? -set_sum : set_sum;
    d = longint'(n) * set_sqsum - mag * mag;
    n2 = n * n;
    var_q16 = (d / n2) * 65536 + ((d % n2) * 65536) / n2;
    st.minimum = set_min[15:0];
    st.mean_q8 = mean[23:0];
    st.std_dev_q8 = 23'(int_sqrt(var_q16));
    st.sample_total = n[16:0];
    st.overflowed = set_ovf;
    return st;
  endfunction

  task automatic add_beat(input logic signed [15:0] s, input logic lst,
                          input logic drn = 1'b0, input logic clm = 1'b0);
    beat_t b;
    b.sample = s;
    b.last = lst;
    b.drain = drn;
    b.calm = clm;
    pending_beats.push_back(b);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Driver: a new beat is offered only when the previous one was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (draining && expected_stats.size() == 0 && !out_valid) draining = 1'b0;
        if (send_idle > 0) begin
          send_idle--;
          in_valid <= 1'b0;
        end else if (draining || pending_beats.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_idle = $urandom_range(1, 12) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_sample <= pending_beats[0].sample;
          in_last <= pending_beats[0].last;
          calm = pending_beats[0].calm;
          if (pending_beats[0].drain) draining = 1'b1;
          void'(pending_beats.pop_front());
        end
      end
      if (recv_idle > 0) begin
        recv_idle--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_idle = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: folds every accepted input beat into the prediction and checks every result beat.
  always @(posedge clk) begin
    set_stats_t want;
    logic       any_beat;
    any_beat = 1'b0;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      any_beat = 1'b1;
      if (set_count < Capacity) begin
        set_sum += in_sample;
        set_sqsum += longint'(in_sample) * longint'(in_sample);
        if (in_sample < set_min) set_min = int'(in_sample);
        set_count++;
      end else begin
        set_ovf = 1'b1;
      end
      if (in_last) begin
        expected_stats.push_back(stats_for_set());
        set_sum = 0;
        set_sqsum = 0;
        set_min = 32767;
        set_count = 0;
        set_ovf = 1'b0;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      any_beat = 1'b1;
      if (expected_stats.size() == 0) begin
        $error("result beat with no expected result");
        fail_count++;
      end else begin
        want = expected_stats.pop_front();
        if (out_minimum !== want.minimum) begin
          $error("minimum: expected %0d, got %0d", want.minimum, out_minimum);
          fail_count++;
        end
        if (out_mean_q8 !== want.mean_q8) begin
          $error("mean_q8: expected %0d, got %0d", want.mean_q8, out_mean_q8);
          fail_count++;
        end
        if (out_std_dev_q8 !== want.std_dev_q8) begin
          $error("std_dev_q8: expected %0d, got %0d", want.std_dev_q8, out_std_dev_q8);
          fail_count++;
        end
        if (out_sample_total !== want.sample_total) begin
          $error("sample_total: expected %0d, got %0d", want.sample_total,
                 out_sample_total);
          fail_count++;
        end
        if (out_overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, out_overflowed);
          fail_count++;
        end
      end
    end
    if (!rst_n || any_beat) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_sample_set_min_mean_stddev_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    int items;
    int len;
    // Directed sets: single extremes and zero, two pairs, a small random set.
    add_beat(16'sh7FFF, 1'b1);
    add_beat(-16'sh8000, 1'b1);
    add_beat(16'sh0000, 1'b1);
    add_beat(16'sh7FFF, 1'b0);
    add_beat(-16'sh8000, 1'b1);
    add_beat(-16'sd1, 1'b0);
    add_beat(-16'sd2, 1'b1);
    for (int i = 0; i < 5; i++) add_beat(16'($urandom), i == 4);
    // The second beat of the next set waits until every earlier result has come out.
    add_beat(16'sd3, 1'b0, 1'b1);
    add_beat(-16'sd5, 1'b1);
    items = 0;
    while (items < 1600) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        add_beat(pick_sample(), i == len - 1, 1'b0, items + i > 1450);
      items += len;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (in_valid || expected_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && expected_stats.size() == 0) begin
      $display("tb_sample_set_min_mean_stddev_unit: clean");
    end else begin
      $display("tb_sample_set_min_mean_stddev_unit: errors");
    end
    $finish;
  end

endmodule
